// ===== design/aging_presence_table_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the aging presence table
// Included by apt_engine to check its own control logic.
// ----------------------------------------------------------------------------
`ifndef AGING_PRESENCE_TABLE_TOP_ASSERT_SVH
`define AGING_PRESENCE_TABLE_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define APT_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("aging presence table: invariant violated");

// A trigger that must be followed by a condition in the next clock cycle.
`define APT_CHECK_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("aging presence table: sequence violated");

`endif

// ===== design/apt_pkg.sv =====
// ----------------------------------------------------------------------------
// apt_pkg
// Types, constants and score arithmetic for the aging presence table.
// ----------------------------------------------------------------------------
`default_nettype none

package apt_pkg;

  localparam int TABLE_DEPTH = 32;

  localparam int ID_W      = 15;
  localparam int SCORE_W   = 16;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 8;
  localparam int KIND_W    = 3;
  localparam int LIVE_W    = 6;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = CNT_W + 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_INC = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_DEC = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] SCORE_INC_RESET = CFG_W'(10);
  localparam logic [CFG_W-1:0] SCORE_DEC_RESET = CFG_W'(2);

  // Event codes reported with each result.
  localparam logic [KIND_W-1:0] EV_REFRESHED = KIND_W'(0);
  localparam logic [KIND_W-1:0] EV_ADDED     = KIND_W'(1);
  localparam logic [KIND_W-1:0] EV_FULL      = KIND_W'(2);
  localparam logic [KIND_W-1:0] EV_DELETED   = KIND_W'(3);
  localparam logic [KIND_W-1:0] EV_NONE      = KIND_W'(4);

  // Saturation bounds held two bits wider than a score.
  localparam logic signed [SCORE_W+1:0] SCORE_HI = (SCORE_W+2)'((2 ** (SCORE_W - 1)) - 1);
  localparam logic signed [SCORE_W+1:0] SCORE_LO = -(SCORE_W+2)'(2 ** (SCORE_W - 1));

  typedef struct packed {
    logic        [ID_W-1:0]    id;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [CFG_W-1:0] inc;
    logic [CFG_W-1:0] dec;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Adds or subtracts an unsigned amount and clamps to the score range.
  function automatic logic signed [SCORE_W-1:0] score_step(
    input logic signed [SCORE_W-1:0] score,
    input logic        [CFG_W-1:0]   amount,
    input logic                      subtract
  );
    logic signed [SCORE_W+1:0] wide;
    logic signed [SCORE_W+1:0] delta;
    logic signed [SCORE_W+1:0] sum;
    wide  = $signed({{2{score[SCORE_W-1]}}, score});
    delta = $signed({{(SCORE_W + 2 - CFG_W){1'b0}}, amount});
    sum   = subtract ? (wide - delta) : (wide + delta);
    if (sum > SCORE_HI) begin
      return SCORE_HI[SCORE_W-1:0];
    end else if (sum < SCORE_LO) begin
      return SCORE_LO[SCORE_W-1:0];
    end
    return sum[SCORE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/apt_if.sv =====
// ----------------------------------------------------------------------------
// apt_if
// Valid/ready channels of the aging presence table.
// ----------------------------------------------------------------------------
`default_nettype none

interface apt_in_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [apt_pkg::ID_W-1:0] object_id;

  modport source (output valid, output cmd, output object_id, input ready);
  modport sink   (input valid, input cmd, input object_id, output ready);
endinterface

interface apt_out_if;
  logic                       valid;
  logic                       ready;
  logic [apt_pkg::KIND_W-1:0] event_kind;
  logic [apt_pkg::ID_W-1:0]   event_id;
  logic [apt_pkg::LIVE_W-1:0] live_count;

  modport source (output valid, output event_kind, output event_id, output live_count,
                  input ready);
  modport sink   (input valid, input event_kind, input event_id, input live_count,
                  output ready);
endinterface

interface apt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [apt_pkg::CFG_IDX_W-1:0] index;
  logic [apt_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/apt_ram.sv =====
// ----------------------------------------------------------------------------
// apt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module apt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/apt_engine.sv =====
// ----------------------------------------------------------------------------
// apt_engine
// Sequencer that scans, ages and compacts the entry memory, one entry a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aging_presence_table_top_assert.svh"

module apt_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  apt_in_if.sink                 in_ch,
  apt_out_if.source              out_ch,
  input  wire apt_pkg::cfg_t     cfg,
  output apt_pkg::mem_req_t      mem_req,
  input  wire apt_pkg::entry_t   rd_entry
);

  import apt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_AGE   = 5'b00100,
    ST_SHIFT = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [KIND_W-1:0]   res_kind_r, res_kind_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [LIVE_W-1:0]   out_live_r, out_live_nxt;

  logic                more1;
  logic                more2;
  logic                full;
  logic signed [SCORE_W-1:0] aged_score;
  logic signed [SCORE_W-1:0] bumped_score;

  assign more1 = (CMP_W'(idx_r) + CMP_W'(1)) < CMP_W'(count_r);
  assign more2 = (CMP_W'(idx_r) + CMP_W'(2)) < CMP_W'(count_r);
  assign full  = (count_r == CNT_W'(TABLE_DEPTH));

  assign aged_score   = score_step(rd_entry.score, cfg.dec, 1'b1);
  assign bumped_score = score_step(rd_entry.score, cfg.inc, 1'b0);

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_kind = out_kind_r;
  assign out_ch.event_id   = out_id_r;
  assign out_ch.live_count = out_live_r;

  // A read meets a write to the same address only where the engine then goes to
  // ST_DONE and does not use the read data.
  always_comb begin
    state_nxt     = state_r;
    id_nxt        = id_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    res_kind_nxt  = res_kind_r;
    res_id_nxt    = res_id_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_live_nxt  = out_live_r;
    mem_req       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          id_nxt  = in_ch.object_id;
          idx_nxt = '0;
          if (count_r == '0) begin
            if (in_ch.cmd) begin
              res_kind_nxt = EV_NONE;
              res_id_nxt   = '0;
            end else begin
              mem_req.we          = 1'b1;
              mem_req.waddr       = '0;
              mem_req.wdata.id    = in_ch.object_id;
              mem_req.wdata.score = $signed(SCORE_W'(cfg.inc));
              count_nxt           = CNT_W'(1);
              res_kind_nxt        = EV_ADDED;
              res_id_nxt          = in_ch.object_id;
            end
            state_nxt = ST_DONE;
          end else begin
            state_nxt = in_ch.cmd ? ST_AGE : ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (rd_entry.id == id_r) begin
          mem_req.we          = 1'b1;
          mem_req.waddr       = idx_r;
          mem_req.wdata.id    = rd_entry.id;
          mem_req.wdata.score = bumped_score;
          res_kind_nxt        = EV_REFRESHED;
          res_id_nxt          = id_r;
          state_nxt           = ST_DONE;
        end else if (more1) begin
          mem_req.raddr = idx_r + IDX_W'(1);
          idx_nxt       = idx_r + IDX_W'(1);
        end else if (full) begin
          res_kind_nxt = EV_FULL;
          res_id_nxt   = '0;
          state_nxt    = ST_DONE;
        end else begin
          mem_req.we          = 1'b1;
          mem_req.waddr       = count_r[IDX_W-1:0];
          mem_req.wdata.id    = id_r;
          mem_req.wdata.score = $signed(SCORE_W'(cfg.inc));
          count_nxt           = count_r + CNT_W'(1);
          res_kind_nxt        = EV_ADDED;
          res_id_nxt          = id_r;
          state_nxt           = ST_DONE;
        end
      end

      ST_AGE: begin
        if (aged_score[SCORE_W-1] || (aged_score == '0)) begin
          // First expired entry: report it and close the gap behind it.
          res_kind_nxt = EV_DELETED;
          res_id_nxt   = rd_entry.id;
          if (more1) begin
            mem_req.raddr = idx_r + IDX_W'(1);
            state_nxt     = ST_SHIFT;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = ST_DONE;
          end
        end else begin
          mem_req.we          = 1'b1;
          mem_req.waddr       = idx_r;
          mem_req.wdata.id    = rd_entry.id;
          mem_req.wdata.score = aged_score;
          if (more1) begin
            mem_req.raddr = idx_r + IDX_W'(1);
            idx_nxt       = idx_r + IDX_W'(1);
          end else begin
            res_kind_nxt = EV_NONE;
            res_id_nxt   = '0;
            state_nxt    = ST_DONE;
          end
        end
      end

      ST_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = rd_entry;
        if (more2) begin
          mem_req.raddr = idx_r + IDX_W'(2);
          idx_nxt       = idx_r + IDX_W'(1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_id_nxt    = res_id_r;
          out_live_nxt  = LIVE_W'(count_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    idx_r      <= idx_nxt;
    res_kind_r <= res_kind_nxt;
    res_id_r   <= res_id_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_live_r <= out_live_nxt;
  end

  `APT_CHECK(a_count_bound, count_r <= CNT_W'(TABLE_DEPTH))
  `APT_CHECK_NEXT(a_accept_leaves_idle, in_ch.valid && in_ch.ready, state_r != ST_IDLE)
  `APT_CHECK(a_no_write_when_done, (state_r == ST_DONE) |-> !mem_req.we)
  `APT_CHECK_NEXT(a_result_loaded, (state_r == ST_DONE) && (!out_valid_r || out_ch.ready),
                  out_valid_r && (state_r == ST_IDLE))

endmodule

`default_nettype wire

// ===== design/aging_presence_table_top.sv =====
// ----------------------------------------------------------------------------
// aging_presence_table_top
// Table of object ids with saturating liveness scores, aged once per round.
//
// A seen transfer (cmd 0) refreshes or appends its id; an end of round
// transfer (cmd 1) ages the scores in order and removes the first entry that
// drops to zero or below, moving the later entries up. Each input transfer
// gives exactly one result transfer. An empty table is handled without a
// scan; otherwise the entries (at most TABLE_DEPTH = 32 live ones) are visited
// one a cycle through the single read port of the entry memory. A result
// waits in an output register, so the next item is taken while it is still
// unread; that item's result then waits in the engine until the first is
// taken. Configuration writes are applied at once and are meant for idle
// periods.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_presence_table_top (
  input  wire logic clk,
  input  wire logic rst_n,
  apt_in_if.sink    in_ch,
  apt_out_if.source out_ch,
  apt_cfg_if.sink   cfg_ch
);

  import apt_pkg::*;

  logic [CFG_W-1:0] score_inc_r;
  logic [CFG_W-1:0] score_dec_r;
  cfg_t             cfg;
  mem_req_t         mem_req;
  logic [ENTRY_W-1:0] rd_word;

  assign cfg_ch.ready = 1'b1;
  assign cfg.inc      = score_inc_r;
  assign cfg.dec      = score_dec_r;

  // Writes to an index outside the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_inc_r <= SCORE_INC_RESET;
      score_dec_r <= SCORE_DEC_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_SCORE_INC) begin
        score_inc_r <= cfg_ch.data;
      end else if (cfg_ch.index == REG_SCORE_DEC) begin
        score_dec_r <= cfg_ch.data;
      end
    end
  end

  apt_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg      (cfg),
    .mem_req  (mem_req),
    .rd_entry (entry_t'(rd_word))
  );

  apt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rd_word)
  );

endmodule

`default_nettype wire
